// File: hdl/ppbr_pkg.sv
package ppbr_pkg;

    // Palette geometry
    localparam int unsigned NumColors  = 13;
    localparam int unsigned NumPixels  = 4;
    localparam int unsigned TieListLen = 11;

    typedef logic [3:0] t_color;
    typedef logic [2:0] t_count;

    // Named palette entries with special meaning
    localparam t_color ColorBlack      = 4'd0;
    localparam t_color ColorBrown      = 4'd4;
    localparam t_color ColorTieDefault = 4'd1;

    // Tie-break order, first entry wins
    localparam t_color TieOrder [TieListLen] = '{
        4'd10, 4'd6, 4'd11, 4'd0, 4'd8, 4'd2, 4'd9, 4'd3, 4'd12, 4'd4, 4'd5
    };

endpackage

// File: hdl/ppbr_select.sv
module ppbr_select (
    input  ppbr_pkg::t_color i_pixels [ppbr_pkg::NumPixels],
    input  logic             i_priority_mode,
    output ppbr_pkg::t_color o_color
);
    import ppbr_pkg::*;

    logic                 valid   [NumPixels];
    t_count               cnt     [NumPixels];
    logic [NumColors-1:0] present;
    t_count               max_ab;
    t_count               max_cd;
    t_count               max_cnt;
    t_count               num_max;
    logic                 tie;
    t_color               winner;
    t_color               tie_pick;

    // Flag pixels that carry a real palette index
    always_comb begin
        for (int i = 0; i < NumPixels; i++) begin
            valid[i] = (i_pixels[i] < t_color'(NumColors));
        end
    end

    // Mark every color present in the block
    always_comb begin
        present = '0;
        for (int c = 0; c < NumColors; c++) begin
            for (int i = 0; i < NumPixels; i++) begin
                if (valid[i] && (i_pixels[i] == t_color'(c))) begin
                    present[c] = 1'b1;
                end
            end
        end
    end

    // Count how often each pixel's color occurs in the block
    always_comb begin
        for (int i = 0; i < NumPixels; i++) begin
            cnt[i] = '0;
            for (int j = 0; j < NumPixels; j++) begin
                if (valid[i] && valid[j] && (i_pixels[j] == i_pixels[i])) begin
                    cnt[i] = cnt[i] + t_count'(1);
                end
            end
        end
    end

    // Find the largest count and how many pixels reach it
    always_comb begin
        max_ab  = (cnt[0] > cnt[1]) ? cnt[0] : cnt[1];
        max_cd  = (cnt[2] > cnt[3]) ? cnt[2] : cnt[3];
        max_cnt = (max_ab > max_cd) ? max_ab : max_cd;
        num_max = '0;
        for (int i = 0; i < NumPixels; i++) begin
            if (cnt[i] == max_cnt) begin
                num_max = num_max + t_count'(1);
            end
        end
    end

    // A tie stands when no color is present or two or more colors share the top count
    assign tie = (max_cnt == t_count'(0))
              || ((max_cnt == t_count'(1)) && (num_max >= t_count'(2)))
              || ((max_cnt == t_count'(2)) && (num_max == t_count'(4)));

    // Take the first pixel holding the top count
    always_comb begin
        winner = i_pixels[0];
        for (int i = NumPixels - 1; i >= 0; i--) begin
            if (cnt[i] == max_cnt) begin
                winner = i_pixels[i];
            end
        end
    end

    // Walk the tie list backward so the earliest present entry lands last
    always_comb begin
        tie_pick = ColorTieDefault;
        for (int k = TieListLen - 1; k >= 0; k--) begin
            if (present[TieOrder[k]]) begin
                tie_pick = TieOrder[k];
            end
        end
    end

    // Black, then brown, override in priority mode
    always_comb begin
        priority if (i_priority_mode && present[ColorBlack]) begin
            o_color = ColorBlack;
        end else if (i_priority_mode && present[ColorBrown]) begin
            o_color = ColorBrown;
        end else if (!tie) begin
            o_color = winner;
        end else begin
            o_color = tie_pick;
        end
    end

endmodule

// File: hdl/priority_palette_block_reduce_core.sv
// Reduces one 2x2 block of palette indices to a single index, one block per clock.
// A word is taken whenever start is high (busy is held low) and its result appears
// on o_chosen_color with the o_valid strobe after passing the input register and then
// the result register, with the count and priority logic between.
// The receiver cannot stall, so results must be taken in the strobe cycle.
// Indices above twelve are ignored. The priority mode bit resets to 1 and should be
// written only while no word is in flight.
module priority_palette_block_reduce_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  ppbr_pkg::t_color i_pixel_top_left,
    input  ppbr_pkg::t_color i_pixel_top_right,
    input  ppbr_pkg::t_color i_pixel_bottom_left,
    input  ppbr_pkg::t_color i_pixel_bottom_right,
    output logic             o_valid,
    output ppbr_pkg::t_color o_chosen_color
);
    import ppbr_pkg::*;

    logic   r_priority_mode;
    logic   r_in_valid;
    t_color r_pixels [NumPixels];
    logic   r_out_valid;
    t_color r_color;
    t_color n_color;

    // Never hold off a word
    assign busy = 1'b0;

    // Hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_priority_mode <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_priority_mode <= i_cfg_wr_data;
        end
    end

    // Capture the incoming block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_pixels[0] <= i_pixel_top_left;
            r_pixels[1] <= i_pixel_top_right;
            r_pixels[2] <= i_pixel_bottom_left;
            r_pixels[3] <= i_pixel_bottom_right;
        end
    end

    // Pick the reduced color
    ppbr_select u_select (
        .i_pixels        (r_pixels),
        .i_priority_mode (r_priority_mode),
        .o_color         (n_color)
    );

    // Register the result and its strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_color <= n_color;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_chosen_color = r_color;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted word produced no result two cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result strobe without an accepted word");

    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_chosen_color < t_color'(NumColors)))
        else $error("chosen color outside the palette");
`endif

endmodule
